### sv/tss_pkg.sv
// Shared constants, types and helpers for the transpose search key table.
`default_nettype none

package tss_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH = 1024;
	localparam int KEY_BITS    = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int POS_W       = IDX_W + 1;

	// Configuration register.
	localparam int CFG_W = 11;
	localparam logic [CFG_W-1:0] ENTRIES_RESET = 11'd1024;

	// Port widths fixed by the interface.
	localparam int IDX_PORT_W = 10;
	localparam int KEY_PORT_W = 16;
	localparam int OPC_W      = 12;
	localparam int HITS_W     = 16;

	// Operation codes.
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef logic [KEY_BITS-1:0] key_t;

	// Per-cell controls driven by the sequencer.
	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

	// Stored keys keep only their low KEY_BITS bits.
	function automatic key_t to_key(input logic [KEY_PORT_W-1:0] v);
		return key_t'(v);
	endfunction

endpackage

`default_nettype wire

### sv/tss_cell.sv
// One table cell: holds a key and passes it to its front neighbor while rotating.
`default_nettype none

module tss_cell
	import tss_pkg::*;
(
	input  wire logic      clk,
	input  wire cell_ctl_t ctl,
	input  wire key_t      shift_in,
	input  wire logic      wr_sel,
	input  wire key_t      wr_key,
	output key_t           key
);

	key_t key_q;

	// Rotation takes the neighbor's key; a load writes the selected cell.
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			key_q <= shift_in;
		end else if (ctl.load && wr_sel) begin
			key_q <= wr_key;
		end
	end

	assign key = key_q;

endmodule

`default_nettype wire

### sv/tss_ctrl.sv
// Sequencer at the head of the cell ring: compare, transpose, counters and results.
`default_nettype none

module tss_ctrl
	import tss_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  opcode,
	input  wire logic [KEY_PORT_W-1:0] key_value,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire key_t                  head0,
	input  wire key_t                  head1,
	output cell_ctl_t                  ctl,
	output key_t                       ins_key,
	output logic                       done,
	output logic                       hit,
	output logic [IDX_PORT_W-1:0]      hit_position,
	output logic [OPC_W-1:0]           op_count,
	output logic [HITS_W-1:0]          hits_so_far
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_ROT  = 2'b10
	} state_t;

	localparam int CMP_W = (POS_W > CFG_W) ? POS_W : CFG_W;
	localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(TABLE_DEPTH - 1);

	state_t            state_q;
	logic [IDX_W-1:0]  cnt_q;
	logic              srch_q;
	logic              swp_q;
	logic              found_q;
	logic [IDX_W-1:0]  fpos_q;
	key_t              key_q;
	key_t              hold_q;
	logic [CFG_W-1:0]  entries_q;
	logic [HITS_W-1:0] hit_total_q;
	logic              res_valid_q;
	logic              res_hit_q;
	logic [IDX_W-1:0]  res_pos_q;
	logic [OPC_W-1:0]  res_ops_q;

	logic              accept;
	logic              rot;
	logic [CMP_W-1:0]  cfg_x;
	logic [CMP_W-1:0]  n_x;
	logic [POS_W-1:0]  n_eff;
	logic [POS_W-1:0]  next_pos;
	logic              found0;
	logic              look;
	logic              found_now;
	logic [IDX_W+1:0]  ops_hit;
	logic [IDX_W+1:0]  ops_miss;

	assign rot    = (state_q == ST_ROT);
	assign busy   = rot;
	assign accept = start && !busy;
	assign cfg_ready = !busy;

	// Searched length, limited to the table depth.
	assign cfg_x = CMP_W'(entries_q);
	assign n_x   = (cfg_x > CMP_W'(TABLE_DEPTH)) ? CMP_W'(TABLE_DEPTH) : cfg_x;
	assign n_eff = POS_W'(n_x);

	// Position 0 is checked at the head; later positions one step ahead so the
	// match can be moved in front of its predecessor as that one goes by.
	assign next_pos  = POS_W'(cnt_q) + POS_W'(1);
	assign found0    = rot && srch_q && (cnt_q == '0) && (n_eff != '0) && (head0 == key_q);
	assign look      = rot && srch_q && !found0 && (next_pos < n_eff) && (head1 == key_q);
	assign found_now = found0 || look;

	// Key fed into the tail of the ring this cycle.
	always_comb begin
		if (swp_q) begin
			ins_key = hold_q;
		end else if (look) begin
			ins_key = head1;
		end else begin
			ins_key = head0;
		end
	end

	assign ctl.shift = rot;
	assign ctl.load  = accept && (opcode == OP_LOAD);

	// Operation counts for both outcomes.
	assign ops_hit  = {1'b0, fpos_q, 1'b0} + (IDX_W+2)'(3);
	assign ops_miss = {n_eff, 1'b0};

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= ENTRIES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			entries_q <= cfg_data;
		end
	end

	// Sequencer and hit bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			srch_q      <= 1'b0;
			swp_q       <= 1'b0;
			found_q     <= 1'b0;
			hit_total_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			swp_q       <= look;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (opcode == OP_SEARCH) begin
							state_q <= ST_ROT;
							cnt_q   <= '0;
							srch_q  <= 1'b1;
							found_q <= 1'b0;
						end else begin
							res_valid_q <= 1'b1;
							found_q     <= 1'b0;
						end
					end
				end
				ST_ROT: begin
					cnt_q <= cnt_q + IDX_W'(1);
					if (found_now) begin
						srch_q  <= 1'b0;
						found_q <= 1'b1;
						if (hit_total_q != {HITS_W{1'b1}}) begin
							hit_total_q <= hit_total_q + HITS_W'(1);
						end
					end
					if (cnt_q == LAST_STEP) begin
						state_q     <= ST_IDLE;
						srch_q      <= 1'b0;
						res_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= to_key(key_value);
		end
		if (look) begin
			hold_q <= head0;
		end
		if (found0) begin
			fpos_q <= '0;
		end else if (look) begin
			fpos_q <= IDX_W'(next_pos);
		end
		if (accept && (opcode == OP_LOAD)) begin
			res_hit_q <= 1'b0;
			res_pos_q <= '0;
			res_ops_q <= '0;
		end else if (rot && (cnt_q == LAST_STEP)) begin
			res_hit_q <= found_q;
			res_pos_q <= found_q ? fpos_q : '0;
			res_ops_q <= found_q ? OPC_W'(ops_hit) : OPC_W'(ops_miss);
		end
	end

	assign done         = res_valid_q;
	assign hit          = res_hit_q;
	assign hit_position = IDX_PORT_W'(res_pos_q);
	assign op_count     = res_ops_q;
	assign hits_so_far  = hit_total_q;

	// A result never shows while the ring is still turning.
	a_no_result_in_rot: assert property (@(posedge clk) disable iff (!arst_n)
		rot |-> !res_valid_q)
		else $error("result strobe during rotation");

	// The last rotation step always delivers a result.
	a_last_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		(rot && (cnt_q == LAST_STEP)) |=> (res_valid_q && !rot))
		else $error("no result after the final rotation step");

	// After a lookahead hit the search has stopped.
	a_swap_ends_search: assert property (@(posedge clk) disable iff (!arst_n)
		swp_q |-> !srch_q)
		else $error("search still active during transpose");

	// The operation count of a hit is always odd.
	a_hit_ops_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_hit_q) |-> res_ops_q[0])
		else $error("even operation count on a hit");

	// Searching only happens while rotating.
	a_search_in_rot: assert property (@(posedge clk) disable iff (!arst_n)
		srch_q |-> rot)
		else $error("search flag outside rotation");

endmodule

`default_nettype wire

### sv/transpose_sequential_search_top.sv
// Top level of the transpose search key table: sequencer and ring of key cells.
//
// Usage. An item is taken on a rising edge with start high and busy low.
// opcode 0 loads key_value into the entry at entry_index (every index names
// an entry of the table); opcode 1 searches the first entries_used entries for it.
// A load raises no busy and its result strobes on done in the next cycle.
// A search turns the ring of cells once: busy stays high while every cell
// passes the head, one entry passing the compare at the head per cycle, and
// the result strobes on done in the cycle after the last step; a new item
// can be taken while done is high. On a hit past position 0 the found key
// is moved one place to the front as it passes its predecessor in the ring.
// Each result is on hit, hit_position, op_count and hits_so_far for exactly
// one cycle while done is high; the receiver cannot stall it.
// entries_used is written on the cfg channel (cfg_valid with cfg_ready),
// which is ready whenever no search is running.
// Reset clears the sequencer, the hit counter and sets entries_used to 1024;
// table contents are undefined until loaded.
`default_nettype none

module transpose_sequential_search_top
	import tss_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  opcode,
	input  wire logic [IDX_PORT_W-1:0] entry_index,
	input  wire logic [KEY_PORT_W-1:0] key_value,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_W-1:0]      cfg_data,
	output logic                       done,
	output logic                       hit,
	output logic [IDX_PORT_W-1:0]      hit_position,
	output logic [OPC_W-1:0]           op_count,
	output logic [HITS_W-1:0]          hits_so_far
);

	cell_ctl_t ctl;
	key_t      ins_key;
	key_t      wr_key;
	key_t      cell_key [TABLE_DEPTH];

	assign wr_key = to_key(key_value);

	// Head sequencer.
	tss_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.key_value    (key_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.head0        (cell_key[0]),
		.head1        (cell_key[1]),
		.ctl          (ctl),
		.ins_key      (ins_key),
		.done         (done),
		.hit          (hit),
		.hit_position (hit_position),
		.op_count     (op_count),
		.hits_so_far  (hits_so_far)
	);

	// Ring of cells: each hands its key one place toward the head per step.
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		key_t shift_src;
		logic sel;

		if (i == TABLE_DEPTH - 1) begin : g_tail
			assign shift_src = ins_key;
		end else begin : g_body
			assign shift_src = cell_key[i+1];
		end

		assign sel = (32'(entry_index) == i);

		tss_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.shift_in (shift_src),
			.wr_sel   (sel),
			.wr_key   (wr_key),
			.key      (cell_key[i])
		);
	end

endmodule

`default_nettype wire
